>>> sv/pngx_pkg.sv
package pngx_pkg;

    // Number of Adler-32 trailer bytes held back at the end of the zlib stream.
    localparam int TRAILER_BYTES_DEF = 4;

    // Depth of the queue between the chunk parser and the zlib back end.
    localparam int QUEUE_DEPTH = 2;

    // Chunk names, first byte in the highest bits.
    localparam logic [31:0] NAME_IDAT = 32'h4944_4154;
    localparam logic [31:0] NAME_IEND = 32'h4945_4E44;

    // Operation codes handed from the parser to the back end.
    localparam logic [1:0] OP_IDAT = 2'd0;
    localparam logic [1:0] OP_ERR  = 2'd1;
    localparam logic [1:0] OP_DONE = 2'd2;

    // Result kinds on the output stream.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } pngx_op_t;

    // The eight bytes of the PNG file signature.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] value;
        unique case (idx)
            3'd0:    value = 8'h89;
            3'd1:    value = 8'h50;
            3'd2:    value = 8'h4E;
            3'd3:    value = 8'h47;
            3'd4:    value = 8'h0D;
            3'd5:    value = 8'h0A;
            3'd6:    value = 8'h1A;
            3'd7:    value = 8'h0A;
            default: value = 8'h00;
        endcase
        return value;
    endfunction

endpackage

>>> sv/pngx_front.sv
module pngx_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    output logic               push,
    output pngx_pkg::pngx_op_t push_op,
    input  logic               queue_full
);

    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_NAME = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;
    localparam logic [2:0] PH_ERR  = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  index_reg, index_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] name_reg, name_next;
    logic [31:0] remain_reg, remain_next;
    logic        accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next   = phase_reg;
        index_next   = index_reg;
        length_next  = length_reg;
        name_next    = name_reg;
        remain_next  = remain_reg;
        push         = 1'b0;
        push_op.op   = pngx_pkg::OP_IDAT;
        push_op.data = in_byte;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SIG:
                begin
                    if (in_byte != pngx_pkg::sig_byte(index_reg))
                    begin
                        phase_next = PH_ERR;
                        index_next = 3'd0;
                        push       = 1'b1;
                        push_op.op = pngx_pkg::OP_ERR;
                    end
                    else if (index_reg == 3'd7)
                    begin
                        index_next = 3'd0;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        index_next = index_reg + 3'd1;
                    end
                end
                PH_LEN:
                begin
                    length_next = {length_reg[23:0], in_byte};
                    if (index_reg == 3'd3)
                    begin
                        index_next = 3'd0;
                        phase_next = PH_NAME;
                    end
                    else
                    begin
                        index_next = index_reg + 3'd1;
                    end
                end
                PH_NAME:
                begin
                    name_next = {name_reg[23:0], in_byte};
                    if (index_reg == 3'd3)
                    begin
                        index_next  = 3'd0;
                        remain_next = length_reg;
                        phase_next  = (length_reg != 32'd0) ? PH_DATA : PH_CRC;
                    end
                    else
                    begin
                        index_next = index_reg + 3'd1;
                    end
                end
                PH_DATA:
                begin
                    remain_next = remain_reg - 32'd1;
                    if (remain_reg == 32'd1)
                    begin
                        phase_next = PH_CRC;
                    end
                    if (name_reg == pngx_pkg::NAME_IDAT)
                    begin
                        push = 1'b1;
                    end
                end
                PH_CRC:
                begin
                    if (index_reg == 3'd3)
                    begin
                        index_next  = 3'd0;
                        length_next = 32'd0;
                        if (name_reg == pngx_pkg::NAME_IEND)
                        begin
                            phase_next = PH_DONE;
                            push       = 1'b1;
                            push_op.op = pngx_pkg::OP_DONE;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    else
                    begin
                        index_next = index_reg + 3'd1;
                    end
                end
                default:
                begin
                    // Finished or failed: later bytes are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            index_reg  <= 3'd0;
            length_reg <= 32'd0;
            name_reg   <= 32'd0;
            remain_reg <= 32'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            length_reg <= length_next;
            name_reg   <= name_next;
            remain_reg <= remain_next;
        end
    end

endmodule

>>> sv/pngx_queue.sv
module pngx_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pngx_pkg::pngx_op_t push_op,
    output logic               full,
    input  logic               pop,
    output pngx_pkg::pngx_op_t pop_op,
    output logic               empty
);

    localparam int PTR_W = (pngx_pkg::QUEUE_DEPTH > 1) ? $clog2(pngx_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(pngx_pkg::QUEUE_DEPTH + 1);

    pngx_pkg::pngx_op_t slot_reg [pngx_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(pngx_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_op  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(pngx_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(pngx_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> sv/pngx_back.sv
module pngx_back
#(
    parameter int TRAILER_BYTES = pngx_pkg::TRAILER_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  pngx_pkg::pngx_op_t op,
    output logic               op_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_kind,
    output logic [7:0]         out_data,
    output logic [7:0]         out_cmf,
    output logic [7:0]         out_flg
);

    localparam int FILL_W = $clog2(TRAILER_BYTES + 1);

    logic [1:0]        seen_reg, seen_next;
    logic [7:0]        cmf_reg, cmf_next;
    logic [7:0]        flg_reg, flg_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        hold_reg [TRAILER_BYTES];
    logic              shift_in;
    logic              valid_reg, valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        data_reg, data_next;
    logic [7:0]        ocmf_reg, ocmf_next;
    logic [7:0]        oflg_reg, oflg_next;

    // Take a new operation whenever the output register is free or being drained.
    assign op_pop = op_valid && (!valid_reg || out_ready);

    always_comb
    begin
        seen_next  = seen_reg;
        cmf_next   = cmf_reg;
        flg_next   = flg_reg;
        fill_next  = fill_reg;
        shift_in   = 1'b0;
        valid_next = valid_reg && !out_ready;
        kind_next  = kind_reg;
        data_next  = data_reg;
        ocmf_next  = ocmf_reg;
        oflg_next  = oflg_reg;
        if (op_pop)
        begin
            unique case (op.op)
                pngx_pkg::OP_IDAT:
                begin
                    if (seen_reg == 2'd0)
                    begin
                        cmf_next  = op.data;
                        seen_next = 2'd1;
                    end
                    else if (seen_reg == 2'd1)
                    begin
                        flg_next  = op.data;
                        seen_next = 2'd2;
                    end
                    else if (fill_reg != FILL_W'(TRAILER_BYTES))
                    begin
                        shift_in  = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        // Delay line is full: the oldest byte leaves as deflate data.
                        shift_in   = 1'b1;
                        valid_next = 1'b1;
                        kind_next  = pngx_pkg::KIND_DATA;
                        data_next  = hold_reg[0];
                        ocmf_next  = 8'd0;
                        oflg_next  = 8'd0;
                    end
                end
                pngx_pkg::OP_ERR:
                begin
                    valid_next = 1'b1;
                    kind_next  = pngx_pkg::KIND_ERR;
                    data_next  = 8'd0;
                    ocmf_next  = 8'd0;
                    oflg_next  = 8'd0;
                end
                pngx_pkg::OP_DONE:
                begin
                    valid_next = 1'b1;
                    kind_next  = pngx_pkg::KIND_DONE;
                    data_next  = 8'd0;
                    ocmf_next  = cmf_reg;
                    oflg_next  = flg_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 2'd0;
            cmf_reg   <= 8'd0;
            flg_reg   <= 8'd0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            cmf_reg   <= cmf_next;
            flg_reg   <= flg_next;
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_reg <= data_next;
        ocmf_reg <= ocmf_next;
        oflg_reg <= oflg_next;
        if (shift_in)
        begin
            for (int i = 0; i < TRAILER_BYTES - 1; i++)
            begin
                hold_reg[i] <= hold_reg[i + 1];
            end
            hold_reg[TRAILER_BYTES - 1] <= op.data;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;
    assign out_cmf   = ocmf_reg;
    assign out_flg   = oflg_reg;

endmodule

>>> sv/png_chunk_idat_extractor_core.sv
// Channel   Dir  Signals                         Contents
// s_axis    in   s_axis_tvalid/tready/tdata[7:0] one byte of the PNG file per word
// m_axis    out  m_axis_tvalid/tready/tdata[23:0] data byte, CMF, FLG
//                m_axis_tuser[1:0]               result kind
//
// Each input word is accepted while the queue is not full, so a byte can follow every cycle
// until the queue fills; the parser updates its chunk state in the cycle the word is accepted.
// A result word passes through the two-entry queue and then the back end's output
// register.
// Reset is asynchronous and active low; after it the parser expects the signature.
// A stalled output fills the queue, and s_axis_tready drops only when it is full.
module png_chunk_idat_extractor_core
#(
    parameter int TRAILER_BYTES = pngx_pkg::TRAILER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [15:8] cmf_byte, [23:16] flg_byte
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    // Operations from the parser toward the zlib back end.
    logic               push;
    pngx_pkg::pngx_op_t push_op;
    logic               queue_full;
    logic               queue_empty;
    logic               pop;
    pngx_pkg::pngx_op_t pop_op;

    logic [7:0]         out_data;
    logic [7:0]         out_cmf;
    logic [7:0]         out_flg;

    // The front end walks the signature and chunk headers and sends only IDAT data
    // bytes, the signature error and the end marker into the queue.
    pngx_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .push       (push),
        .push_op    (push_op),
        .queue_full (queue_full)
    );

    pngx_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (queue_full),
        .pop     (pop),
        .pop_op  (pop_op),
        .empty   (queue_empty)
    );

    // The back end captures CMF and FLG, holds the trailer bytes back and drives
    // the registered output word.
    pngx_back
    #(
        .TRAILER_BYTES (TRAILER_BYTES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (!queue_empty),
        .op        (pop_op),
        .op_pop    (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (out_data),
        .out_cmf   (out_cmf),
        .out_flg   (out_flg)
    );

    assign m_axis_tdata = {out_flg, out_cmf, out_data};

endmodule

>>> test/png_idat_stream_checker.sv
module png_idat_stream_checker
#(
    parameter int TRAILER = pngx_pkg::TRAILER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          results_due
);

    // The PNG signature, first byte in the highest bits.
    localparam logic [63:0] SIGNATURE = 64'h8950_4E47_0D0A_1A0A;

    typedef enum logic [2:0] {
        WALK_SIG,
        WALK_LEN,
        WALK_NAME,
        WALK_DATA,
        WALK_CRC,
        WALK_DONE,
        WALK_ERR
    } walk_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] cmf;
        logic [7:0] flg;
    } png_result_t;

    walk_t       walk;
    logic [2:0]  field_pos;
    logic [31:0] len_shift;
    logic [31:0] name_shift;
    logic [31:0] data_left;
    logic [1:0]  zlib_hdr_count;
    logic [7:0]  cmf_seen;
    logic [7:0]  flg_seen;
    logic [7:0]  adler_hold [TRAILER];
    int          hold_count;
    png_result_t results_q [$];
    png_result_t want;

    task automatic clear_walker();
        walk = WALK_SIG;
        field_pos = '0;
        len_shift = '0;
        name_shift = '0;
        data_left = '0;
        zlib_hdr_count = '0;
        cmf_seen = '0;
        flg_seen = '0;
        for (int i = 0; i < TRAILER; i++)
            adler_hold[i] = '0;
        hold_count = 0;
        results_q.delete();
    endtask

    // The zlib stream: two header bytes, then a delay line that swallows the Adler trailer.
    task automatic feed_zlib(input logic [7:0] b);
        png_result_t res;
        if (zlib_hdr_count == 2'd0)
        begin
            cmf_seen = b;
            zlib_hdr_count = 2'd1;
        end
        else if (zlib_hdr_count == 2'd1)
        begin
            flg_seen = b;
            zlib_hdr_count = 2'd2;
        end
        else if (hold_count < TRAILER)
        begin
            adler_hold[hold_count] = b;
            hold_count++;
        end
        else
        begin
            res = '{kind: pngx_pkg::KIND_DATA, data: adler_hold[0], cmf: 8'h00, flg: 8'h00};
            results_q.insert(results_q.size(), res);
            for (int i = 0; i < TRAILER - 1; i++)
                adler_hold[i] = adler_hold[i + 1];
            adler_hold[TRAILER - 1] = b;
        end
    endtask

    task automatic parse_file_byte(input logic [7:0] b);
        png_result_t res;
        case (walk)
            WALK_SIG:
            begin
                if (b != SIGNATURE[63 - 8 * field_pos -: 8])
                begin
                    walk = WALK_ERR;
                    field_pos = '0;
                    res = '{kind: pngx_pkg::KIND_ERR, data: 8'h00, cmf: 8'h00, flg: 8'h00};
                    results_q.insert(results_q.size(), res);
                end
                else if (field_pos == 3'd7)
                begin
                    field_pos = '0;
                    walk = WALK_LEN;
                end
                else
                    field_pos++;
            end
            WALK_LEN:
            begin
                len_shift = {len_shift[23:0], b};
                if (field_pos == 3'd3)
                begin
                    field_pos = '0;
                    walk = WALK_NAME;
                end
                else
                    field_pos++;
            end
            WALK_NAME:
            begin
                name_shift = {name_shift[23:0], b};
                if (field_pos == 3'd3)
                begin
                    field_pos = '0;
                    data_left = len_shift;
                    walk = (len_shift != 32'd0) ? WALK_DATA : WALK_CRC;
                end
                else
                    field_pos++;
            end
            WALK_DATA:
            begin
                data_left--;
                if (data_left == 32'd0)
                    walk = WALK_CRC;
                if (name_shift == pngx_pkg::NAME_IDAT)
                    feed_zlib(b);
            end
            WALK_CRC:
            begin
                if (field_pos == 3'd3)
                begin
                    field_pos = '0;
                    len_shift = '0;
                    if (name_shift == pngx_pkg::NAME_IEND)
                    begin
                        walk = WALK_DONE;
                        res = '{kind: pngx_pkg::KIND_DONE, data: 8'h00,
                                cmf: cmf_seen, flg: flg_seen};
                        results_q.insert(results_q.size(), res);
                    end
                    else
                        walk = WALK_LEN;
                end
                else
                    field_pos++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_walker();
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_q.size() == 0)
                    report($sformatf("result word with nothing expected, kind %0d tdata %h",
                                     m_tuser, m_tdata));
                else
                begin
                    want = results_q.pop_front();
                    if (m_tuser !== want.kind)
                        report($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
                    if (m_tdata[7:0] !== want.data)
                        report($sformatf("data byte %h, expected %h", m_tdata[7:0], want.data));
                    if (m_tdata[15:8] !== want.cmf)
                        report($sformatf("CMF %h, expected %h", m_tdata[15:8], want.cmf));
                    if (m_tdata[23:16] !== want.flg)
                        report($sformatf("FLG %h, expected %h", m_tdata[23:16], want.flg));
                end
            end
            if (s_tvalid && s_tready)
                parse_file_byte(s_tdata);
        end
        results_due = results_q.size();
    end

endmodule

>>> test/png_chunk_idat_extractor_core_tb.sv
module png_chunk_idat_extractor_core_tb;

    localparam int ITEMS          = 1500;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    // While quiet is set, neither the file source nor the result sink inserts gaps.
    logic        quiet = 1'b0;
    int          sent_count = 0;
    int          stall_cycles = 0;
    int          mismatches;
    int          results_due;

    always #1 clk = ~clk;

    png_chunk_idat_extractor_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    png_idat_stream_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // The result sink stalls about 7 percent of the time, except in the quiet stretch.
    always @(posedge clk)
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 7);

    // The run is stuck if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one file byte, with a random gap in front, and returns once it is accepted.
    // Valid stays high into the next call so that back-to-back bytes need no gap.
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        sent_count++;
        quiet <= (sent_count >= 300 && sent_count < 700);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Chunk fields are big-endian.
    task automatic send_field(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[8 * i +: 8]);
    endtask

    // A whole chunk with random data bytes and a random CRC, which the block never checks.
    task automatic send_chunk(input logic [31:0] name, input int unsigned len);
        send_field(len);
        send_field(name);
        repeat (len)
            send_byte(8'($urandom_range(0, 255)));
        send_field($urandom());
    endtask

    task automatic send_signature();
        for (int i = 0; i < 8; i++)
            send_byte(pngx_pkg::sig_byte(3'(i)));
    endtask

    // Names that must not feed the zlib path or end the file, near misses among them.
    function automatic logic [31:0] pick_other_name();
        logic [31:0] name;
        case ($urandom_range(0, 7))
            0:       name = 32'h4948_4452;  // IHDR
            1:       name = 32'h504C_5445;  // PLTE
            2:       name = 32'h7445_5874;  // tEXt
            3:       name = 32'h4944_4155;  // one bit off IDAT in the last byte
            4:       name = 32'h4844_4154;  // one bit off IDAT in the first byte
            5:       name = 32'h4945_4E43;  // three bits off IEND in the last byte
            6:       name = 32'h4A45_4E44;  // two bits off IEND in the first byte
            default: name = $urandom();
        endcase
        return name;
    endfunction

    // Holds the source off until every expected result has left the block.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    // One reset per run, so each run walks one file. Most runs send a long well-formed file;
    // some send a file whose IDAT stream is too short to reach past the trailer, and some
    // break the signature, after which every byte is ignored.
    initial
    begin
        int          mode;
        int          pos;
        int          r;
        int unsigned len;
        bit          drained;

        drained = 1'b0;
        mode = $urandom_range(0, 9);
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        if (mode == 0)
        begin
            // Broken signature at a random position, then bytes that must be ignored.
            pos = $urandom_range(0, 7);
            for (int i = 0; i < pos; i++)
                send_byte(pngx_pkg::sig_byte(3'(i)));
            send_byte(pngx_pkg::sig_byte(3'(pos)) ^ 8'($urandom_range(1, 255)));
            wait_results_drained();
            repeat (ITEMS - pos - 1)
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (mode == 1)
        begin
            // Fewer IDAT bytes than the header and trailer take; CMF and FLG may never come.
            send_signature();
            while (sent_count < ITEMS)
                send_chunk(pick_other_name(), $urandom_range(0, 24));
            send_chunk(pngx_pkg::NAME_IDAT, $urandom_range(0, 5));
            wait_results_drained();
            repeat (3)
                send_chunk(pick_other_name(), $urandom_range(0, 24));
            send_chunk(pngx_pkg::NAME_IEND, 0);
            repeat (16)
                send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Directed opening: an empty IDAT chunk, then a short one with the byte extremes.
            send_signature();
            send_chunk(pngx_pkg::NAME_IDAT, 0);
            send_field(32'd5);
            send_field(pngx_pkg::NAME_IDAT);
            send_byte(8'h00);
            send_byte(8'hFF);
            send_byte(8'h5A);
            send_byte(8'hA5);
            send_byte(8'h80);
            send_field($urandom());

            // Random chunk mix: mostly IDAT, with other and empty chunks in between,
            // and now and then a long chunk of 100 to 300 data bytes.
            while (sent_count < ITEMS)
            begin
                if (!drained && sent_count >= 900)
                begin
                    wait_results_drained();
                    drained = 1'b1;
                end
                r = $urandom_range(0, 99);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 24);
                if (r < 60)
                    send_chunk(pngx_pkg::NAME_IDAT, len);
                else if (r < 70)
                    send_chunk(pick_other_name(), 0);
                else
                    send_chunk(pick_other_name(), len);
            end

            // IEND may carry data; bytes after its CRC must be ignored.
            send_chunk(pngx_pkg::NAME_IEND, $urandom_range(0, 2));
            repeat (16)
                send_byte(8'($urandom_range(0, 255)));
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && results_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
